@@ hdl/pffba_pkg.sv @@
package pffba_pkg;

    localparam int NUM_PAGES  = 16;
    localparam int PAGE_UNITS = 256;
    localparam int PG_W       = 4;
    localparam int OFF_W      = 8;
    localparam int LEN_W      = 9;
    localparam int CFG_W      = 5;
    localparam int ADDR_W     = PG_W + OFF_W;
    localparam int NODE_W     = 2 * LEN_W;

    localparam logic [LEN_W-1:0] END_MARK  = LEN_W'(PAGE_UNITS);
    localparam logic [LEN_W-1:0] FULL_PAGE = LEN_W'(PAGE_UNITS);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_FAIL    = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_PAGE,
        S_A_RD,
        S_A_EVAL,
        S_A_LINK,
        S_M_RD,
        S_M_EVAL,
        S_F_RD,
        S_F_EVAL,
        S_F_FIN,
        S_DONE
    } t_state;

    // write request to the node memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } t_mem_wr;

endpackage

@@ hdl/pffba_ram.sv @@
module pffba_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/paged_first_fit_block_allocator_unit.sv @@
// Channel   Dir  Handshake             Payload
// s_axis    in   i_s_tvalid/o_s_tready tdata: page_index, block_offset, size_units; tuser: func
// m_axis    out  o_m_tvalid/i_m_tready tdata: result_page, result_offset, page_largest_free;
//                                      tuser: status
// cfg       in   i_cfg_valid/o_cfg_ready data: pages_in_use
//
// Walk: a request visits the page's free list one node at a time; allocate also steps
// past pages whose largest free block is too small, and walks the list again when the
// page maximum is recomputed. The single-port-per-direction node memory sets this pace.
// Reset: an init pass writes the offset-zero node of each of the 16 pages; no request beat is
// taken meanwhile. A new request is taken while a finished result waits in the output
// register.
module paged_first_fit_block_allocator_unit
    import pffba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // page_index[3:0], block_offset[11:4], size_units[20:12]
    input  logic [0:0]  i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // result_page[3:0], result_offset[11:4], page_largest_free[20:12]
    output logic [0:0]  o_m_tuser,  // status[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_piu;
    logic [LEN_W-1:0] r_head [NUM_PAGES];
    logic [LEN_W-1:0] r_largest [NUM_PAGES];

    logic [PG_W-1:0]  r_pg, n_pg;
    logic [OFF_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_size, n_size;
    logic [CFG_W-1:0] r_pcnt, n_pcnt;
    logic [LEN_W-1:0] r_cur, n_cur;
    logic [LEN_W-1:0] r_prev, n_prev;
    logic [LEN_W-1:0] r_prev_len, n_prev_len;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_nxt, n_nxt;
    logic [LEN_W-1:0] r_steps, n_steps;
    logic [LEN_W-1:0] r_best, n_best;
    logic             r_split, n_split;
    logic             r_have_lo, n_have_lo;
    logic             r_have_hi, n_have_hi;
    logic [OFF_W-1:0] r_lo_pos, n_lo_pos;
    logic [LEN_W-1:0] r_lo_len, n_lo_len;
    logic [LEN_W-1:0] r_hi_len, n_hi_len;
    logic             r_res_st, n_res_st;
    logic [OFF_W-1:0] r_res_off, n_res_off;
    logic [PG_W-1:0]  r_init, n_init;

    logic             r_out_valid;
    logic             r_out_st;
    logic [PG_W-1:0]  r_out_pg;
    logic [OFF_W-1:0] r_out_off;
    logic [LEN_W-1:0] r_out_lf;

    logic             head_we, lf_we, out_load;
    logic [LEN_W-1:0] head_wd, lf_wd;
    t_mem_wr          mem_wr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [NODE_W-1:0] mem_rdata;
    logic [LEN_W-1:0] rd_len, rd_nxt;
    logic [CFG_W-1:0] limit;
    logic [LEN_W-1:0] repl;
    logic [LEN_W+1:0] total;
    logic [OFF_W-1:0] free_pos;

    assign rd_len   = mem_rdata[LEN_W-1:0];
    assign rd_nxt   = mem_rdata[NODE_W-1:LEN_W];
    assign limit    = (r_piu > CFG_W'(NUM_PAGES)) ? CFG_W'(NUM_PAGES) : r_piu;
    assign repl     = r_split ? (r_cur + r_size) : r_nxt;
    assign total    = (LEN_W+2)'(r_size) + (LEN_W+2)'(r_lo_len) + (LEN_W+2)'(r_hi_len);
    assign free_pos = r_have_lo ? r_lo_pos : r_pos;

    pffba_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NUM_PAGES * PAGE_UNITS)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (mem_wr.we),
        .i_waddr(mem_wr.addr),
        .i_wdata(mem_wr.data),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {3'b000, r_out_lf, r_out_off, r_out_pg};
    assign o_m_tuser   = r_out_st;

    // sequencer: next state, memory accesses and table updates
    always_comb begin
        n_state    = r_state;
        n_pg       = r_pg;
        n_pos      = r_pos;
        n_size     = r_size;
        n_pcnt     = r_pcnt;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_prev_len = r_prev_len;
        n_len      = r_len;
        n_nxt      = r_nxt;
        n_steps    = r_steps;
        n_best     = r_best;
        n_split    = r_split;
        n_have_lo  = r_have_lo;
        n_have_hi  = r_have_hi;
        n_lo_pos   = r_lo_pos;
        n_lo_len   = r_lo_len;
        n_hi_len   = r_hi_len;
        n_res_st   = r_res_st;
        n_res_off  = r_res_off;
        n_init     = r_init;
        head_we    = 1'b0;
        head_wd    = r_head[r_pg];
        lf_we      = 1'b0;
        lf_wd      = r_largest[r_pg];
        out_load   = 1'b0;
        mem_wr     = '{we: 1'b0, addr: {r_pg, r_cur[OFF_W-1:0]}, data: '0};
        mem_raddr  = {r_pg, r_cur[OFF_W-1:0]};
        unique case (r_state)
            S_INIT: begin
                mem_wr = '{we: 1'b1, addr: {r_init, OFF_W'(0)}, data: {END_MARK, FULL_PAGE}};
                n_init = r_init + 1'b1;
                if (r_init == PG_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_pg      = i_s_tdata[3:0];
                    n_pos     = i_s_tdata[11:4];
                    n_size    = i_s_tdata[20:12];
                    n_pcnt    = '0;
                    n_res_st  = ST_FAIL;
                    n_res_off = '0;
                    n_prev    = END_MARK;
                    n_steps   = '0;
                    n_have_lo = 1'b0;
                    n_have_hi = 1'b0;
                    n_lo_pos  = '0;
                    n_lo_len  = '0;
                    n_hi_len  = '0;
                    n_cur     = r_head[i_s_tdata[3:0]];
                    if (i_s_tuser[0] == FUNC_ALLOC) begin
                        if (i_s_tdata[20:12] == '0 || i_s_tdata[20:12] > FULL_PAGE) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_A_PAGE;
                        end
                    end else begin
                        if (i_s_tdata[20:12] == '0 ||
                            ({1'b0, i_s_tdata[20:12]} + 10'(i_s_tdata[11:4])) >
                            10'(PAGE_UNITS)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_PAGE: begin
                n_pg    = r_pcnt[PG_W-1:0];
                n_cur   = r_head[r_pcnt[PG_W-1:0]];
                n_prev  = END_MARK;
                n_steps = '0;
                if (r_pcnt >= limit) begin
                    n_state = S_DONE;
                end else if (r_largest[r_pcnt[PG_W-1:0]] >= r_size) begin
                    n_state = S_A_RD;
                end else begin
                    n_pcnt = r_pcnt + 1'b1;
                end
            end
            S_A_RD: begin
                if (r_cur[LEN_W-1] || r_steps[LEN_W-1]) begin
                    n_pcnt  = r_pcnt + 1'b1;
                    n_state = S_A_PAGE;
                end else begin
                    n_state = S_A_EVAL;
                end
            end
            S_A_EVAL: begin
                n_len   = rd_len;
                n_nxt   = rd_nxt;
                n_split = (rd_len > r_size) &&
                          ((10'(r_cur) + 10'(r_size)) < 10'(PAGE_UNITS));
                if (rd_len >= r_size) begin
                    // write the split remainder
                    if (n_split) begin
                        mem_wr = '{we: 1'b1, addr: {r_pg, OFF_W'(r_cur + r_size)},
                                   data: {rd_nxt, rd_len - r_size}};
                        if (r_prev == r_cur + r_size) begin
                            n_prev_len = rd_len - r_size;
                        end
                    end
                    n_state = S_A_LINK;
                end else begin
                    n_prev     = r_cur;
                    n_prev_len = rd_len;
                    n_cur      = rd_nxt;
                    n_steps    = r_steps + 1'b1;
                    n_state    = S_A_RD;
                end
            end
            S_A_LINK: begin
                n_res_st  = ST_OK;
                n_res_off = r_cur[OFF_W-1:0];
                if (r_prev[LEN_W-1]) begin
                    head_we = 1'b1;
                    head_wd = repl;
                    n_cur   = repl;
                end else begin
                    mem_wr = '{we: 1'b1, addr: {r_pg, r_prev[OFF_W-1:0]},
                               data: {repl, r_prev_len}};
                    n_cur  = r_head[r_pg];
                end
                n_steps = '0;
                n_best  = '0;
                if (r_len == r_largest[r_pg]) begin
                    n_state = S_M_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_RD: begin
                if (r_cur[LEN_W-1] || r_steps[LEN_W-1]) begin
                    lf_we   = 1'b1;
                    lf_wd   = r_best;
                    n_state = S_DONE;
                end else begin
                    n_state = S_M_EVAL;
                end
            end
            S_M_EVAL: begin
                if (rd_len > r_best) begin
                    n_best = rd_len;
                end
                n_cur   = rd_nxt;
                n_steps = r_steps + 1'b1;
                n_state = S_M_RD;
            end
            S_F_RD: begin
                if (r_cur[LEN_W-1] || r_steps[LEN_W-1] || (r_have_lo && r_have_hi)) begin
                    n_state = S_F_FIN;
                end else begin
                    n_state = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                n_cur   = rd_nxt;
                n_steps = r_steps + 1'b1;
                n_state = S_F_RD;
                if ((!r_have_lo && (10'(r_cur) + 10'(rd_len)) == 10'(r_pos)) ||
                    (!(!r_have_lo && (10'(r_cur) + 10'(rd_len)) == 10'(r_pos)) &&
                     !r_have_hi && r_cur == (LEN_W'(r_pos) + r_size))) begin
                    // unlink the neighbor
                    if (!r_have_lo && (10'(r_cur) + 10'(rd_len)) == 10'(r_pos)) begin
                        n_have_lo = 1'b1;
                        n_lo_len  = rd_len;
                        n_lo_pos  = r_cur[OFF_W-1:0];
                    end else begin
                        n_have_hi = 1'b1;
                        n_hi_len  = rd_len;
                    end
                    if (r_prev[LEN_W-1]) begin
                        head_we = 1'b1;
                        head_wd = rd_nxt;
                    end else begin
                        mem_wr = '{we: 1'b1, addr: {r_pg, r_prev[OFF_W-1:0]},
                                   data: {rd_nxt, r_prev_len}};
                    end
                end else begin
                    n_prev     = r_cur;
                    n_prev_len = rd_len;
                end
            end
            S_F_FIN: begin
                lf_wd = (total > (LEN_W+2)'(PAGE_UNITS)) ? FULL_PAGE : total[LEN_W-1:0];
                mem_wr = '{we: 1'b1, addr: {r_pg, free_pos}, data: {r_head[r_pg], lf_wd}};
                head_we   = 1'b1;
                head_wd   = LEN_W'(free_pos);
                lf_we     = (lf_wd > r_largest[r_pg]);
                n_res_st  = ST_OK;
                n_res_off = free_pos;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_piu   <= CFG_W'(1);
            for (int p = 0; p < NUM_PAGES; p++) begin
                r_head[p]    <= '0;
                r_largest[p] <= FULL_PAGE;
            end
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            if (i_cfg_valid) begin
                r_piu <= i_cfg_data;
            end
            if (head_we) begin
                r_head[r_pg] <= head_wd;
            end
            if (lf_we) begin
                r_largest[r_pg] <= lf_wd;
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge i_clk) begin
        r_pg       <= n_pg;
        r_pos      <= n_pos;
        r_size     <= n_size;
        r_pcnt     <= n_pcnt;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_len <= n_prev_len;
        r_len      <= n_len;
        r_nxt      <= n_nxt;
        r_steps    <= n_steps;
        r_best     <= n_best;
        r_split    <= n_split;
        r_have_lo  <= n_have_lo;
        r_have_hi  <= n_have_hi;
        r_lo_pos   <= n_lo_pos;
        r_lo_len   <= n_lo_len;
        r_hi_len   <= n_hi_len;
        r_res_st   <= n_res_st;
        r_res_off  <= n_res_off;
    end

    // output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_st  <= r_res_st;
            r_out_pg  <= (r_res_st == ST_OK) ? r_pg : '0;
            r_out_off <= (r_res_st == ST_OK) ? r_res_off : '0;
            r_out_lf  <= (r_res_st == ST_OK) ? r_largest[r_pg] : '0;
        end
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_wr.we)
        else $error("node memory written while idle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] == ST_FAIL) |-> (o_m_tdata == '0))
        else $error("failed result carries nonzero fields");

    a_lf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[20:12] <= FULL_PAGE))
        else $error("largest free above page size");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before taken");

endmodule

@@ tb/paged_first_fit_block_allocator_unit_checker.sv @@
`timescale 1ns / 1ps

module paged_first_fit_block_allocator_unit_checker
    import pffba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic             status;
        logic [PG_W-1:0]  page;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] largest;
    } t_reply;

    t_reply reply_q[$];
    int     search_pages;
    int     head_of[NUM_PAGES];
    int     max_of[NUM_PAGES];
    int     next_of[NUM_PAGES][PAGE_UNITS];
    int     len_of[NUM_PAGES][PAGE_UNITS];

    assign o_pending = reply_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic int largest_in_list(int pg);
        int best, cur, steps;
        best = 0;
        cur = head_of[pg];
        steps = 0;
        while (cur < PAGE_UNITS && steps < PAGE_UNITS) begin
            if (len_of[pg][cur] > best) best = len_of[pg][cur];
            cur = next_of[pg][cur];
            steps++;
        end
        return best;
    endfunction

    // first fit within one page; returns offset or -1
    function automatic int carve_block(int pg, int size);
        int prev, cur, steps, len, nxt, repl;
        prev = PAGE_UNITS;
        cur = head_of[pg];
        steps = 0;
        while (cur < PAGE_UNITS && steps < PAGE_UNITS) begin
            len = len_of[pg][cur];
            nxt = next_of[pg][cur];
            if (len >= size) begin
                repl = nxt;
                if (len > size && cur + size < PAGE_UNITS) begin
                    repl = cur + size;
                    next_of[pg][repl] = nxt;
                    len_of[pg][repl] = len - size;
                end
                if (prev >= PAGE_UNITS) head_of[pg] = repl;
                else next_of[pg][prev] = repl;
                if (len == max_of[pg]) max_of[pg] = largest_in_list(pg);
                return cur;
            end
            prev = cur;
            cur = nxt;
            steps++;
        end
        return -1;
    endfunction

    function automatic int merge_free(int pg, int pos, int size);
        bit have_lo, have_hi, drop;
        int lo, hi, prev, cur, steps, len, nxt, total;
        have_lo = 0; have_hi = 0; lo = 0; hi = 0;
        prev = PAGE_UNITS;
        cur = head_of[pg];
        steps = 0;
        while (cur < PAGE_UNITS && steps < PAGE_UNITS && !(have_lo && have_hi)) begin
            len = len_of[pg][cur];
            nxt = next_of[pg][cur];
            drop = 0;
            if (!have_lo && cur + len == pos) begin
                have_lo = 1; lo = cur; drop = 1;
            end else if (!have_hi && cur == pos + size) begin
                have_hi = 1; hi = cur; drop = 1;
            end
            if (drop) begin
                if (prev >= PAGE_UNITS) head_of[pg] = nxt;
                else next_of[pg][prev] = nxt;
            end else begin
                prev = cur;
            end
            cur = nxt;
            steps++;
        end
        total = size;
        if (have_lo) begin
            total += len_of[pg][lo];
            pos = lo;
        end
        if (have_hi) total += len_of[pg][hi];
        if (total > PAGE_UNITS) total = PAGE_UNITS;
        next_of[pg][pos] = head_of[pg];
        len_of[pg][pos] = total;
        head_of[pg] = pos;
        if (total > max_of[pg]) max_of[pg] = total;
        return pos;
    endfunction

    function automatic t_reply predict_reply(logic func, int pg, int off, int size);
        t_reply r;
        int lim, got;
        r = '0;
        r.status = ST_FAIL;
        if (func == FUNC_ALLOC) begin
            lim = (search_pages > NUM_PAGES) ? NUM_PAGES : search_pages;
            if (size != 0 && size <= PAGE_UNITS) begin
                for (int i = 0; i < lim; i++) begin
                    if (max_of[i] >= size) begin
                        got = carve_block(i, size);
                        if (got >= 0) begin
                            r.status = ST_OK;
                            r.page = PG_W'(i);
                            r.offset = OFF_W'(got);
                            r.largest = LEN_W'(max_of[i]);
                            break;
                        end
                    end
                end
            end
        end else if (size != 0 && off + size <= PAGE_UNITS) begin
            got = merge_free(pg, off, size);
            r.status = ST_OK;
            r.page = PG_W'(pg);
            r.offset = OFF_W'(got);
            r.largest = LEN_W'(max_of[pg]);
        end
        return r;
    endfunction

    // track beats on all channels
    always @(posedge i_clk) begin
        t_reply got, want;
        if (!i_rst_n) begin
            o_errors = 0;
            reply_q.delete();
            search_pages = 1;
            for (int p = 0; p < NUM_PAGES; p++) begin
                head_of[p] = 0;
                max_of[p] = PAGE_UNITS;
                for (int o = 0; o < PAGE_UNITS; o++) begin
                    next_of[p][o] = 0;
                    len_of[p][o] = 0;
                end
                next_of[p][0] = PAGE_UNITS;
                len_of[p][0] = PAGE_UNITS;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) search_pages = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                reply_q.push_back(predict_reply(i_s_tuser[0], i_s_tdata[3:0],
                                                i_s_tdata[11:4], i_s_tdata[20:12]));
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser[0];
                got.page = i_m_tdata[3:0];
                got.offset = i_m_tdata[11:4];
                got.largest = i_m_tdata[20:12];
                if (reply_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = reply_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.page != want.page)
                        report_mismatch("result_page", got.page, want.page);
                    if (got.offset != want.offset)
                        report_mismatch("result_offset", got.offset, want.offset);
                    if (got.largest != want.largest)
                        report_mismatch("page_largest_free", got.largest, want.largest);
                end
            end
        end
    end

endmodule

@@ tb/paged_first_fit_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module paged_first_fit_block_allocator_unit_tb;
    import pffba_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          hold_sink;
    bit          busy_sink;

    // live blocks that a well-formed free can return
    int          live_pg[$];
    int          live_off[$];
    int          live_sz[$];

    paged_first_fit_block_allocator_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    paged_first_fit_block_allocator_unit_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off
    always @(posedge clk) begin
        if (!rst_n || hold_sink || busy_sink) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        busy_sink = 0;
        forever begin
            @(posedge clk);
            if (rst_n && !hold_sink && $urandom_range(0, 40) == 0) begin
                busy_sink = 1;
                repeat (gap_len()) @(posedge clk);
                busy_sink = 0;
            end
        end
    end

    // the block takes no beat until it has finished the last request, so a short gap before each costs little
    task automatic send_req(logic func, int pg, int off, int size);
        repeat (1 + gap_len()) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {3'b0, 9'(size), 8'(off), 4'(pg)};
        do @(posedge clk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_pages(int value);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // model sees each allocate's result later; clear the live list after a drain
        live_pg.delete(); live_off.delete(); live_sz.delete();
    endtask

    // allocate and remember nothing; frees mostly return harvested live blocks, else random fields
    task automatic random_phase(int count, int max_size);
        int k, pg, off, size;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                size = (max_size > 1 && $urandom_range(0, 9) == 0) ? max_size
                       : $urandom_range(1, max_size);
                send_req(FUNC_ALLOC, $urandom_range(0, 15), $urandom_range(0, 255), size);
            end else if (live_sz.size() != 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, live_sz.size() - 1);
                send_req(FUNC_FREE, live_pg[k], live_off[k], live_sz[k]);
                live_pg.delete(k); live_off.delete(k); live_sz.delete(k);
            end else begin
                pg = $urandom_range(0, 15);
                off = $urandom_range(0, 255);
                size = $urandom_range(0, 511);
                send_req(FUNC_FREE, pg, off, size);
            end
        end
    endtask

    // harvest allocated blocks from result beats for later frees
    int   last_size;
    int   size_q[$];
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            size_q.push_back(s_tuser[0] ? -1 : int'(s_tdata[20:12]));
        if (rst_n && m_tvalid && m_tready && size_q.size() != 0) begin
            last_size = size_q.pop_front();
            if (last_size > 0 && m_tuser[0] == ST_OK) begin
                live_pg.push_back(m_tdata[3:0]);
                live_off.push_back(m_tdata[11:4]);
                live_sz.push_back(last_size);
            end
        end
    end

    initial begin
        cycles = 0;
        hold_sink = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and rejects
        send_req(FUNC_ALLOC, 15, 255, 0);
        send_req(FUNC_ALLOC, 0, 0, 257);
        send_req(FUNC_ALLOC, 0, 0, 511);
        send_req(FUNC_ALLOC, 0, 0, 256);
        send_req(FUNC_ALLOC, 0, 0, 1);
        send_req(FUNC_FREE, 0, 0, 256);
        send_req(FUNC_FREE, 0, 255, 1);
        send_req(FUNC_FREE, 0, 255, 2);
        send_req(FUNC_FREE, 0, 10, 0);
        send_req(FUNC_FREE, 0, 0, 256);
        send_req(FUNC_FREE, 15, 100, 20);
        send_req(FUNC_ALLOC, 0, 0, 10);
        send_req(FUNC_ALLOC, 0, 0, 10);
        send_req(FUNC_ALLOC, 0, 0, 10);
        send_req(FUNC_FREE, 0, 10, 10);
        send_req(FUNC_FREE, 0, 0, 10);
        send_req(FUNC_FREE, 0, 20, 10);
        send_req(FUNC_ALLOC, 0, 0, 255);
        send_req(FUNC_ALLOC, 0, 0, 2);

        write_pages(0);
        send_req(FUNC_ALLOC, 0, 0, 1);
        write_pages(31);
        send_req(FUNC_ALLOC, 0, 0, 256);
        send_req(FUNC_ALLOC, 0, 0, 256);

        // long receiver hold-off while requests pile up
        hold_sink = 1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_sink = 0;
            end
            random_phase(20, 32);
        join

        write_pages(16);
        random_phase(150, 40);
        write_pages(1);
        random_phase(120, 256);
        write_pages(4);
        random_phase(120, 24);
        write_pages($urandom_range(2, 15));
        random_phase(90, 64);

        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
